>>> rtl/servo_gripper_sequencer_macros.svh
// assertion helpers shared by the sequencer rtl
`ifndef SERVO_GRIPPER_SEQUENCER_MACROS_SVH
`define SERVO_GRIPPER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every clock outside reset
`define SGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication, checked on every clock outside reset
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`else

`define SGS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SGS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/sgs_pkg.sv
package sgs_pkg;

   // configuration register file
   localparam int unsigned NUM_CFG = 7;
   localparam int unsigned CFG_INDEX_W = 3;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CFG_CENTER     = 3'd0,
      CFG_POS_ONE    = 3'd1,
      CFG_POS_TWO    = 3'd2,
      CFG_POS_THREE  = 3'd3,
      CFG_POS_FOUR   = 3'd4,
      CFG_FLOOR      = 3'd5,
      CFG_CEILING    = 3'd6
   } cfg_index_type;

   typedef logic [NUM_CFG-1:0][7:0] cfg_regs_type;

   // event kinds
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_CAN  = 2'd1;
   localparam logic [1:0] CMD_UART = 2'd2;

   // can frame match
   localparam logic [28:0] GRIPPER_FRAME_ID = 29'h10;
   localparam logic [7:0]  GRIPPER_BYTE_ZERO = 8'h06;
   localparam logic [7:0]  GRIPPER_BYTE_ONE = 8'h01;

   // timing thresholds
   localparam logic [15:0] HOLD_CENTER    = 16'd100;
   localparam logic [15:0] HOLD_POWER_OFF = 16'd150;
   localparam logic [15:0] HOLD_POWER_ON  = 16'd10;
   localparam logic [6:0]  STARTUP_APPLY  = 7'd10;
   localparam logic [6:0]  STARTUP_DONE   = 7'd100;
   localparam logic [2:0]  STATE_LAST     = 3'd4;
   localparam logic [2:0]  STATE_WRAP     = 3'd5;

   // uart characters
   localparam logic [7:0] CHAR_FWD    = 8'h66;
   localparam logic [7:0] CHAR_BACK   = 8'h62;
   localparam logic [7:0] CHAR_SWITCH = 8'h73;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_FOUR   = 8'h34;

   typedef struct packed {
      logic [1:0]  command;
      logic [28:0] frame_id;
      logic [7:0]  frame_byte_zero;
      logic [7:0]  frame_byte_one;
      logic [7:0]  camera_byte;
      logic [7:0]  serial_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] pulse_width;
      logic       servo_on;
      logic [2:0] gripper_state;
      logic       frame_start;
   } rsp_item_type;

endpackage

>>> rtl/servo_gripper_sequencer.sv
// Servo gripper sequencer: takes one event per transfer (timer tick, CAN frame or UART byte)
// and returns one result per event with the pulse width, servo power, gripper state and a
// frame-start flag. An event is registered on input, processed from the input register, and
// its result is held in an output register, so a new event is taken every clock unless the
// result side stalls; the only limit on throughput is the result side, which back-pressures
// through the input register.
`include "servo_gripper_sequencer_macros.svh"

module servo_gripper_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [28:0]                     req_frame_id,
   input  logic [7:0]                      req_frame_byte_zero,
   input  logic [7:0]                      req_frame_byte_one,
   input  logic [7:0]                      req_camera_byte,
   input  logic [7:0]                      req_serial_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_pulse_width,
   output logic                            rsp_servo_on,
   output logic [2:0]                      rsp_gripper_state,
   output logic                            rsp_frame_start,
   input  logic                            csr_write_enable,
   input  logic [sgs_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_write_data
);
   import sgs_pkg::*;

   cfg_regs_type cfg;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;

   sgs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // input stage moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.command         <= req_command;
         in_item_ff.frame_id        <= req_frame_id;
         in_item_ff.frame_byte_zero <= req_frame_byte_zero;
         in_item_ff.frame_byte_one  <= req_frame_byte_one;
         in_item_ff.camera_byte     <= req_camera_byte;
         in_item_ff.serial_byte     <= req_serial_byte;
      end
   end

   sgs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pulse_width   = out_item_ff.pulse_width;
   assign rsp_servo_on      = out_item_ff.servo_on;
   assign rsp_gripper_state = out_item_ff.gripper_state;
   assign rsp_frame_start   = out_item_ff.frame_start;

   `SGS_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `SGS_ASSERT_NEXT(a_result_loaded, clock, reset, advance, out_valid_ff)
   `SGS_ASSERT_IMPL(a_no_overwrite, clock, reset, advance && out_valid_ff, rsp_ready)

endmodule

>>> rtl/sgs_csr.sv
module sgs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sgs_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [7:0]                    csr_write_data,
   output sgs_pkg::cfg_regs_type         cfg
);
   import sgs_pkg::*;

   cfg_regs_type cfg_ff, cfg_in;

   // write decode, indexes past the last register are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CFG_CENTER:    cfg_in[CFG_CENTER]    = csr_write_data;
            CFG_POS_ONE:   cfg_in[CFG_POS_ONE]   = csr_write_data;
            CFG_POS_TWO:   cfg_in[CFG_POS_TWO]   = csr_write_data;
            CFG_POS_THREE: cfg_in[CFG_POS_THREE] = csr_write_data;
            CFG_POS_FOUR:  cfg_in[CFG_POS_FOUR]  = csr_write_data;
            CFG_FLOOR:     cfg_in[CFG_FLOOR]     = csr_write_data;
            CFG_CEILING:   cfg_in[CFG_CEILING]   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_CENTER]    <= 8'd180;
         cfg_ff[CFG_POS_ONE]   <= 8'd206;
         cfg_ff[CFG_POS_TWO]   <= 8'd240;
         cfg_ff[CFG_POS_THREE] <= 8'd158;
         cfg_ff[CFG_POS_FOUR]  <= 8'd130;
         cfg_ff[CFG_FLOOR]     <= 8'd56;
         cfg_ff[CFG_CEILING]   <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/sgs_core.sv
`include "servo_gripper_sequencer_macros.svh"

module sgs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sgs_pkg::req_item_type item,
   input  sgs_pkg::cfg_regs_type cfg,
   output sgs_pkg::rsp_item_type result
);
   import sgs_pkg::*;

   logic [7:0]  width_ff, width_in;
   logic [2:0]  state_ff, state_in;
   logic [7:0]  last_cam_ff, last_cam_in;
   logic        pending_ff, pending_in;
   logic [15:0] hold_ff, hold_in;
   logic [6:0]  startup_ff, startup_in;
   logic        pup_ff, pup_in;
   logic        power_ff, power_in;
   logic        phase_ff, phase_in;
   logic        started;

   logic        frame_match;
   logic [7:0]  last_eff;
   logic [2:0]  state_inc;
   logic signed [9:0] jog;

   assign frame_match = (item.frame_id == GRIPPER_FRAME_ID)
                     && (item.frame_byte_zero == GRIPPER_BYTE_ZERO)
                     && (item.frame_byte_one == GRIPPER_BYTE_ONE);
   assign last_eff  = (pup_ff || (startup_ff < STARTUP_DONE)) ? item.camera_byte : last_cam_ff;
   assign state_inc = state_ff + 3'd1;

   // next state for one event
   always_comb begin
      width_in    = width_ff;
      state_in    = state_ff;
      last_cam_in = last_cam_ff;
      pending_in  = pending_ff;
      hold_in     = hold_ff;
      startup_in  = startup_ff;
      pup_in      = pup_ff;
      power_in    = power_ff;
      phase_in    = phase_ff;
      started     = 1'b0;
      jog         = $signed({2'b00, width_ff});
      case (item.command)
         CMD_TICK: begin
            if (hold_ff != 16'hFFFF) begin
               hold_in = hold_ff + 16'd1;
            end
            phase_in = ~phase_ff;
            // frame step on every second tick
            if (phase_in) begin
               started = 1'b1;
               if (pending_ff) begin
                  hold_in = '0;
                  if (startup_ff > STARTUP_APPLY) begin
                     power_in = 1'b1;
                     if (state_ff <= STATE_LAST) begin
                        width_in = cfg[state_ff];
                     end
                     pending_in = 1'b0;
                  end
               end
               if (hold_in > HOLD_CENTER) begin
                  width_in = cfg[CFG_CENTER];
               end
               if ((width_in == cfg[CFG_CENTER]) && (hold_in > HOLD_POWER_OFF)) begin
                  power_in = 1'b0;
               end
               if ((hold_in > HOLD_POWER_ON) && pup_ff) begin
                  power_in = 1'b1;
                  pup_in   = 1'b0;
               end
               if (startup_ff < STARTUP_DONE) begin
                  startup_in = startup_ff + 7'd1;
               end
            end
         end
         CMD_CAN: begin
            // camera change advances the gripper sequence
            if (frame_match) begin
               if (item.camera_byte != last_eff) begin
                  pending_in = 1'b1;
                  state_in   = state_inc;
               end
               if (state_in == STATE_WRAP) begin
                  state_in = '0;
               end
               last_cam_in = item.camera_byte;
            end
         end
         CMD_UART: begin
            // jog, preset or toggle, then clamp floor first and ceiling last
            case (item.serial_byte) inside
               CHAR_FWD:    jog = jog + 10'sd1;
               CHAR_BACK:   jog = jog - 10'sd1;
               CHAR_SWITCH: power_in = ~power_ff;
               [CHAR_ZERO:CHAR_FOUR]: jog = $signed({2'b00, cfg[item.serial_byte[2:0]]});
               default: ;
            endcase
            if (jog < $signed({2'b00, cfg[CFG_FLOOR]})) begin
               jog = $signed({2'b00, cfg[CFG_FLOOR]});
            end
            if (jog > $signed({2'b00, cfg[CFG_CEILING]})) begin
               jog = $signed({2'b00, cfg[CFG_CEILING]});
            end
            width_in = jog[7:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 8'd180;
         state_ff    <= '0;
         last_cam_ff <= '0;
         pending_ff  <= 1'b0;
         hold_ff     <= '0;
         startup_ff  <= '0;
         pup_ff      <= 1'b1;
         power_ff    <= 1'b0;
         phase_ff    <= 1'b0;
      end else if (step) begin
         width_ff    <= width_in;
         state_ff    <= state_in;
         last_cam_ff <= last_cam_in;
         pending_ff  <= pending_in;
         hold_ff     <= hold_in;
         startup_ff  <= startup_in;
         pup_ff      <= pup_in;
         power_ff    <= power_in;
         phase_ff    <= phase_in;
      end
   end

   // result reflects the state after this event
   assign result.pulse_width   = width_in;
   assign result.servo_on      = power_in;
   assign result.gripper_state = state_in;
   assign result.frame_start   = started;

   `SGS_ASSERT_IMPL(a_state_range, clock, reset, 1'b1, state_ff <= STATE_LAST)
   `SGS_ASSERT_IMPL(a_frame_on_tick, clock, reset, started, item.command == CMD_TICK)
   `SGS_ASSERT_IMPL(a_powerup_enables, clock, reset, $fell(pup_ff), power_ff)
   `SGS_ASSERT_NEXT(a_startup_frozen, clock, reset, !step, $stable(startup_ff))

endmodule
